/* hdl/fsk_morse_beacon_keyer_top_assert.svh */
// Assertion macros for the FSK Morse beacon keyer top level.
// Each macro expands to one labeled concurrent assertion clocked by i_clk.
// Both macros expect i_clk and i_rst_n to be visible where they are used.
`ifndef FSK_MORSE_BEACON_KEYER_TOP_ASSERT_SVH
`define FSK_MORSE_BEACON_KEYER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMBK_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FMBK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/fmbk_pkg.sv */
// Shared types, constants and helper functions for the FSK Morse beacon keyer.
// Used by fmbk_step and fsk_morse_beacon_keyer_top; depends on nothing else.
`timescale 1ns / 1ps

package fmbk_pkg;

    // Pattern geometry and tone grouping.
    localparam int MAX_SYMBOLS     = 32;
    localparam int TONES_PER_GROUP = 5;

    localparam int PAT_W   = 64;
    localparam int LEN_W   = 6;
    localparam int TPU_W   = 16;
    localparam int DLY_W   = 8;
    localparam int TONE_W  = 4;
    localparam int POS_W   = $clog2(MAX_SYMBOLS + 1);
    localparam int IDX_W   = $clog2(MAX_SYMBOLS);
    localparam int CNT_W   = $clog2(TONES_PER_GROUP);
    localparam int CFG_W   = 64;
    localparam int CIDX_W  = 2;
    localparam int DATA_W  = 8;

    // Reset values of the configuration registers.
    localparam logic [PAT_W-1:0] RST_PATTERN = '0;
    localparam logic [LEN_W-1:0] RST_LENGTH  = LEN_W'(21);
    localparam logic [TPU_W-1:0] RST_TPU     = TPU_W'(4482);
    localparam logic [DLY_W-1:0] RST_DELAY   = DLY_W'(20);

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_PATTERN = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] REG_LENGTH  = CIDX_W'(1);
    localparam logic [CIDX_W-1:0] REG_TPU     = CIDX_W'(2);
    localparam logic [CIDX_W-1:0] REG_DELAY   = CIDX_W'(3);

    // Symbol codes; the fourth code is sent as a dit.
    localparam logic [1:0] SYM_DIT = 2'd0;
    localparam logic [1:0] SYM_DAH = 2'd1;
    localparam logic [1:0] SYM_GAP = 2'd2;

    localparam logic [DLY_W-1:0] PAUSE_MAX = '1;

    typedef struct packed {
        logic [PAT_W-1:0] pattern_symbols;
        logic [LEN_W-1:0] pattern_length;
        logic [TPU_W-1:0] ticks_per_unit;
        logic [DLY_W-1:0] delay_units;
    } t_cfg;

    typedef struct packed {
        logic [TPU_W-1:0]  tick_count;
        logic [POS_W-1:0]  symbol_position;
        logic [CNT_W-1:0]  dit_count;
        logic [CNT_W-1:0]  dah_count;
        logic [TONE_W-1:0] loaded_tone;
        logic              key_state;
        logic              run_phase;
        logic [DLY_W-1:0]  pause_count;
    } t_state;

    typedef struct packed {
        logic              phase;
        logic              unit_strobe;
        logic              tone_load;
        logic [TONE_W-1:0] tone_index;
        logic              key_on;
    } t_result;

    // Picks the 2-bit symbol at a pattern position.
    function automatic logic [1:0] sym_at(input logic [PAT_W-1:0] pat,
                                          input logic [IDX_W-1:0] idx);
        return pat[2*idx +: 2];
    endfunction

endpackage

/* hdl/fmbk_step.sv */
// Next-state and result logic for one timer tick of the Morse beacon keyer.
// Purely combinational; depends on fmbk_pkg for types and constants.
`timescale 1ns / 1ps

module fmbk_step (
    input  fmbk_pkg::t_cfg    i_cfg,
    input  fmbk_pkg::t_state  i_state,
    input  logic              i_run,
    output fmbk_pkg::t_state  o_state,
    output fmbk_pkg::t_result o_result
);
    import fmbk_pkg::*;

    t_state            n_state;
    logic              w_unit;
    logic              w_load;
    logic              w_send;
    logic [POS_W-1:0]  w_lim;
    logic [DLY_W-1:0]  w_pause_inc;
    logic [1:0]        w_sym;
    logic [TONE_W-1:0] w_tone;

    // Effective pattern length, clipped to the symbol capacity.
    always_comb begin
        if (i_cfg.pattern_length > LEN_W'(MAX_SYMBOLS)) begin
            w_lim = POS_W'(MAX_SYMBOLS);
        end else begin
            w_lim = POS_W'(i_cfg.pattern_length);
        end
    end

    // Tick counter, pause handling and sending of one unit.
    always_comb begin
        n_state     = i_state;
        w_unit      = 1'b0;
        w_load      = 1'b0;
        w_send      = 1'b0;
        w_pause_inc = i_state.pause_count;
        w_sym       = SYM_DIT;
        w_tone      = '0;

        if (i_run) begin
            if (i_state.tick_count < i_cfg.ticks_per_unit) begin
                n_state.tick_count = i_state.tick_count + 1'b1;
            end else begin
                n_state.tick_count = '0;
                w_unit             = 1'b1;
            end
        end

        if (w_unit) begin
            w_send = 1'b1;
            if (i_state.run_phase) begin
                if (i_state.pause_count != PAUSE_MAX) begin
                    w_pause_inc = i_state.pause_count + 1'b1;
                end
                n_state.pause_count = w_pause_inc;
                if (w_pause_inc >= i_cfg.delay_units) begin
                    // Pause over: restart the pattern on this unit.
                    n_state.run_phase       = 1'b0;
                    n_state.pause_count     = '0;
                    n_state.symbol_position = '0;
                    n_state.dit_count       = '0;
                    n_state.dah_count       = '0;
                end else begin
                    w_send = 1'b0;
                end
            end
        end

        if (w_send) begin
            // A letter gap clears the counters and yields to the next symbol.
            if (n_state.symbol_position < w_lim &&
                sym_at(i_cfg.pattern_symbols, n_state.symbol_position[IDX_W-1:0]) == SYM_GAP)
            begin
                n_state.dit_count       = '0;
                n_state.dah_count       = '0;
                n_state.symbol_position = n_state.symbol_position + 1'b1;
            end
            if (n_state.symbol_position >= w_lim) begin
                n_state.key_state   = 1'b0;
                n_state.run_phase   = 1'b1;
                n_state.pause_count = '0;
            end else begin
                w_sym = sym_at(i_cfg.pattern_symbols, n_state.symbol_position[IDX_W-1:0]);
                if (w_sym == SYM_DAH) begin
                    w_tone = TONE_W'(TONES_PER_GROUP) + TONE_W'(n_state.dah_count);
                    if (n_state.dah_count < CNT_W'(TONES_PER_GROUP - 1)) begin
                        n_state.dah_count = n_state.dah_count + 1'b1;
                    end
                end else begin
                    w_tone = TONE_W'(n_state.dit_count);
                    if (n_state.dit_count < CNT_W'(TONES_PER_GROUP - 1)) begin
                        n_state.dit_count = n_state.dit_count + 1'b1;
                    end
                end
                n_state.symbol_position = n_state.symbol_position + 1'b1;
                n_state.key_state       = 1'b1;
                if (w_tone != n_state.loaded_tone) begin
                    n_state.loaded_tone = w_tone;
                    w_load              = 1'b1;
                end
            end
        end
    end

    // Result fields show the state after this tick.
    assign o_state              = n_state;
    assign o_result.key_on      = n_state.key_state;
    assign o_result.tone_index  = n_state.loaded_tone;
    assign o_result.tone_load   = w_load;
    assign o_result.unit_strobe = w_unit;
    assign o_result.phase       = n_state.run_phase;

endmodule

/* hdl/fsk_morse_beacon_keyer_top.sv */
// Top level of the multi-tone FSK Morse beacon keyer: config, pipeline.
// Depends on fmbk_pkg, fmbk_step and fsk_morse_beacon_keyer_top_assert.svh.
`timescale 1ns / 1ps
`include "fsk_morse_beacon_keyer_top_assert.svh"

// Usage:
// The slave stream carries one word per timer tick; bit 0 of tdata is run.
// Each accepted word produces exactly one result word on the master stream
// with key_on, tone_index, tone_load, unit_strobe and phase.
// The pipeline has an input register and a result register: a word accepted
// into the input register moves into the result register once it frees, and is offered there.
// Throughput is one word per clock while the receiver takes results, set by the
// single pass through the step logic between the two registers.
// When the receiver stalls, the result register holds its word and the input
// register can still take one more word; after that tready drops until the
// result is taken. No word is lost or repeated.
// Configuration registers are written through i_cfg_we, i_cfg_index and
// i_cfg_wdata while the streams are idle; the user must ensure this, the block does not enforce it.
// Reset (synchronous, active low) empties both registers, clears the keyer
// state and restores the configuration defaults: length 21, a unit every
// 4483 ticks (ticks_per_unit 4482), and a 20-unit pause.

module fsk_morse_beacon_keyer_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Slave stream. tdata: [0] run, [7:1] zero.
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [fmbk_pkg::DATA_W-1:0]  i_s_axis_tdata,
    // Master stream. tdata: [0] key_on, [4:1] tone_index, [5] tone_load,
    // [6] unit_strobe, [7] phase.
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [fmbk_pkg::DATA_W-1:0]  o_m_axis_tdata,
    // Configuration write port.
    input  logic                         i_cfg_we,
    input  logic [fmbk_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [fmbk_pkg::CFG_W-1:0]   i_cfg_wdata
);
    import fmbk_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_in_valid;
    logic    r_in_run;
    logic    r_out_valid;
    logic    w_advance;
    logic    w_in_accept;

    // Handshake: the result register frees when empty or being taken.
    assign w_advance       = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_symbols <= RST_PATTERN;
            r_cfg.pattern_length  <= RST_LENGTH;
            r_cfg.ticks_per_unit  <= RST_TPU;
            r_cfg.delay_units     <= RST_DELAY;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PATTERN: r_cfg.pattern_symbols <= i_cfg_wdata;
                REG_LENGTH:  r_cfg.pattern_length  <= i_cfg_wdata[LEN_W-1:0];
                REG_TPU:     r_cfg.ticks_per_unit  <= i_cfg_wdata[TPU_W-1:0];
                REG_DELAY:   r_cfg.delay_units     <= i_cfg_wdata[DLY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
        if (w_in_accept) begin
            r_in_run <= i_s_axis_tdata[0];
        end
    end

    // Step logic for the word in the input register.
    fmbk_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_run    (r_in_run),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Keyer state and result register advance together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
        if (w_advance && r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_result.phase, r_result.unit_strobe, r_result.tone_load,
                              r_result.tone_index, r_result.key_on};

    // A tone load only happens on a unit boundary.
    `FMBK_ASSERT_SAME(a_load_on_unit, r_out_valid && r_result.tone_load, r_result.unit_strobe, "tone load without unit strobe")
    // The key is never on during the pause.
    `FMBK_ASSERT_SAME(a_key_off_in_pause, r_out_valid && r_result.phase, !r_result.key_on, "key on while pausing")
    // Tone index stays within the two tone groups.
    `FMBK_ASSERT_SAME(a_tone_range, r_out_valid, r_result.tone_index <= TONE_W'(2 * TONES_PER_GROUP - 1), "tone index out of range")
    // A stalled result word stays pending.
    `FMBK_ASSERT_NEXT(a_stall_holds, r_out_valid && !i_m_axis_tready, r_out_valid && $stable(r_result), "result lost under stall")

endmodule

/* test/fsk_morse_beacon_keyer_top_tb.sv */
// Self-checking testbench for the FSK Morse beacon keyer top level.
// Drives timer ticks on the slave stream, predicts every result word and checks the master stream.
// Depends on fmbk_pkg and fsk_morse_beacon_keyer_top only.
`timescale 1ns / 1ps

module fsk_morse_beacon_keyer_top_tb;

    import fmbk_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 9;
    localparam int HOLD_CYCLES  = 200;
    localparam int TIMEOUT_NS   = CLK_PERIOD * 200_000;
    localparam logic [1:0] SYM_SPARE = 2'd3;

    // Block ports.
    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    // tdata: [0] run, [7:1] zero.
    logic [DATA_W-1:0]    i_s_axis_tdata  = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    // tdata: [0] key_on, [4:1] tone_index, [5] tone_load, [6] unit_strobe, [7] phase.
    logic [DATA_W-1:0]    o_m_axis_tdata;
    logic                 i_cfg_we        = 1'b0;
    logic [CIDX_W-1:0]    i_cfg_index     = '0;
    logic [CFG_W-1:0]     i_cfg_wdata     = '0;

    // Keyer configuration as the block should hold it.
    logic [PAT_W-1:0]  cfg_pattern;
    logic [LEN_W-1:0]  cfg_length;
    logic [TPU_W-1:0]  cfg_tpu;
    logic [DLY_W-1:0]  cfg_delay;

    // Keyer state as the block should hold it.
    logic [TPU_W-1:0]  st_ticks;
    logic [LEN_W-1:0]  st_pos;
    logic [2:0]        st_dits;
    logic [2:0]        st_dahs;
    logic [TONE_W-1:0] st_tone;
    logic              st_key;
    logic              st_pausing;
    logic [DLY_W-1:0]  st_pause;

    // Expected result words, oldest first.
    t_result tone_words_due[$];

    int  ticks_sent    = 0;
    int  words_checked = 0;
    int  mismatches    = 0;
    int  units_due     = 0;
    int  loads_due     = 0;
    int  restarts_due  = 0;
    bit  idle_on       = 1'b1;
    bit  hold_toggle   = 1'b0;
    bit  hold_seen     = 1'b0;
    int  hold_left     = 0;

    fsk_morse_beacon_keyer_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Advances the keyer by one tick and returns the word it should produce.
    task automatic keyer_tick(input bit run, output t_result r);
        logic [LEN_W-1:0]  lim;
        logic [1:0]        code;
        logic [TONE_W-1:0] tone;
        bit                unit;
        bit                load;
        bit                send;
        unit = 1'b0;
        load = 1'b0;
        if (run) begin
            if (st_ticks < cfg_tpu) begin
                st_ticks++;
            end else begin
                st_ticks = '0;
                unit = 1'b1;
            end
        end
        if (unit) begin
            send = 1'b1;
            // During the pause a unit only counts, until the pause is over.
            if (st_pausing) begin
                if (st_pause != PAUSE_MAX) st_pause++;
                if (st_pause >= cfg_delay) begin
                    st_pausing = 1'b0;
                    st_pause   = '0;
                    st_pos     = '0;
                    st_dits    = '0;
                    st_dahs    = '0;
                    restarts_due++;
                end else begin
                    send = 1'b0;
                end
            end
            if (send) begin
                lim = (cfg_length > MAX_SYMBOLS) ? LEN_W'(MAX_SYMBOLS) : cfg_length;
                // A letter gap clears the counters and is consumed in this unit.
                if (st_pos < lim && cfg_pattern[2*st_pos[4:0] +: 2] == SYM_GAP) begin
                    st_dits = '0;
                    st_dahs = '0;
                    st_pos++;
                end
                if (st_pos >= lim) begin
                    st_key     = 1'b0;
                    st_pausing = 1'b1;
                    st_pause   = '0;
                end else begin
                    code = cfg_pattern[2*st_pos[4:0] +: 2];
                    if (code == SYM_DAH) begin
                        tone = TONE_W'(TONES_PER_GROUP) + TONE_W'(st_dahs);
                        if (st_dahs < TONES_PER_GROUP - 1) st_dahs++;
                    end else begin
                        tone = TONE_W'(st_dits);
                        if (st_dits < TONES_PER_GROUP - 1) st_dits++;
                    end
                    st_pos++;
                    st_key = 1'b1;
                    if (tone != st_tone) begin
                        st_tone = tone;
                        load    = 1'b1;
                    end
                end
            end
        end
        units_due += unit;
        loads_due += load;
        r.key_on      = st_key;
        r.tone_index  = st_tone;
        r.tone_load   = load;
        r.unit_strobe = unit;
        r.phase       = st_pausing;
    endtask

    // Offers one tick word, waits until it is taken and records its expected result.
    task automatic send_tick(input bit run);
        t_result due;
        if (idle_on && $urandom_range(99) < 10) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(DATA_W-1){1'b0}}, run};
        do @(posedge i_clk); while (!o_s_axis_tready);
        keyer_tick(run, due);
        tone_words_due.push_back(due);
        ticks_sent++;
    endtask

    task automatic send_ticks(input int count, input int run_pct);
        repeat (count) send_tick($urandom_range(99) < run_pct);
    endtask

    // Stops offering ticks until every expected word has come back.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (tone_words_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_PATTERN: cfg_pattern = value;
            REG_LENGTH:  cfg_length  = value[LEN_W-1:0];
            REG_TPU:     cfg_tpu     = value[TPU_W-1:0];
            REG_DELAY:   cfg_delay   = value[DLY_W-1:0];
            default: ;
        endcase
    endtask

    // Writes all four registers once the block is idle.
    task automatic configure(input logic [PAT_W-1:0] pat, input logic [CFG_W-1:0] len,
                             input logic [CFG_W-1:0] tpu, input logic [CFG_W-1:0] dly);
        wait_drained();
        cfg_write(REG_PATTERN, pat);
        cfg_write(REG_LENGTH, len);
        cfg_write(REG_TPU, tpu);
        cfg_write(REG_DELAY, dly);
    endtask

    // With the reset settings a unit is thousands of ticks away; ticks only count or hold.
    task automatic test_reset_defaults();
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    // Dit and dah saturation, the spare code, gap after gap, trailing gap, zero pause,
    // and every running tick being a unit.
    task automatic test_symbol_rules();
        logic [1:0]       seq [15] = '{SYM_DIT, SYM_DIT, SYM_DIT, SYM_DIT, SYM_DIT,
                                       SYM_SPARE, SYM_GAP, SYM_DAH, SYM_DAH, SYM_DAH,
                                       SYM_DAH, SYM_DAH, SYM_GAP, SYM_GAP, SYM_GAP};
        logic [PAT_W-1:0] pat;
        pat = '0;
        for (int i = 0; i < 15; i++) pat[2*i +: 2] = seq[i];
        configure(pat, 15, 0, 0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        repeat (13) send_tick(1'b1);
    endtask

    // Length zero only pauses.
    task automatic test_empty_pattern();
        configure({$urandom, $urandom}, 0, 0, 1);
        repeat (3) send_tick(1'b1);
    endtask

    // Longest pause with no idling on either side.
    task automatic test_longest_pause();
        configure({$urandom, $urandom}, 2, 0, 255);
        idle_on = 1'b0;
        send_ticks(270, 97);
        idle_on = 1'b1;
    endtask

    // The receiver holds off for a long stretch while ticks keep coming.
    task automatic test_output_backpressure();
        configure({$urandom, $urandom}, 32, 1, 2);
        idle_on = 1'b0;
        hold_toggle <= ~hold_toggle;
        send_ticks(40, 90);
        idle_on = 1'b1;
    endtask

    // Longest unit: the tick counter runs without reaching a boundary.
    task automatic test_slowest_unit();
        configure({$urandom, $urandom}, 63, 65535, 20);
        send_ticks(12, 70);
    endtask

    // Random patterns and settings, mostly short units so that patterns run through.
    task automatic test_random_settings(input int phases);
        logic [PAT_W-1:0] pat;
        logic [CFG_W-1:0] len;
        logic [CFG_W-1:0] tpu;
        logic [CFG_W-1:0] dly;
        for (int p = 0; p < phases; p++) begin
            pat = ($urandom_range(5) == 0) ? '1 : {$urandom, $urandom};
            case ($urandom_range(5))
                0:       len = 1;
                1:       len = 32;
                2:       len = CFG_W'($urandom_range(63, 33));
                default: len = CFG_W'($urandom_range(31, 2));
            endcase
            // Upper bits beyond the length register width must be dropped.
            len[CFG_W-1:LEN_W] = (CFG_W-LEN_W)'({$urandom, $urandom});
            tpu = CFG_W'(($urandom_range(3) == 0) ? $urandom_range(12) : $urandom_range(3));
            case ($urandom_range(3))
                0:       dly = 0;
                1:       dly = 1;
                default: dly = CFG_W'($urandom_range(6));
            endcase
            configure(pat, len, tpu, dly);
            send_ticks(80, 85);
        end
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        hold_seen <= hold_toggle;
        if (hold_toggle != hold_seen) begin
            hold_left       <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= !(idle_on && $urandom_range(99) < 10);
        end
    end

    task automatic report(input string field, input int due, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, due, got);
        mismatches++;
    endtask

    // Each accepted result word is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_result due;
        t_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_result'(o_m_axis_tdata);
            if (tone_words_due.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h",
                         $time, o_m_axis_tdata);
                mismatches++;
            end else begin
                due = tone_words_due.pop_front();
                if (got.key_on !== due.key_on) report("key_on", due.key_on, got.key_on);
                if (got.tone_index !== due.tone_index)
                    report("tone_index", due.tone_index, got.tone_index);
                if (got.tone_load !== due.tone_load)
                    report("tone_load", due.tone_load, got.tone_load);
                if (got.unit_strobe !== due.unit_strobe)
                    report("unit_strobe", due.unit_strobe, got.unit_strobe);
                if (got.phase !== due.phase) report("phase", due.phase, got.phase);
            end
            words_checked++;
        end
    end

    initial begin
        cfg_pattern = RST_PATTERN;
        cfg_length  = RST_LENGTH;
        cfg_tpu     = RST_TPU;
        cfg_delay   = RST_DELAY;
        st_ticks    = '0;
        st_pos      = '0;
        st_dits     = '0;
        st_dahs     = '0;
        st_tone     = '0;
        st_key      = 1'b0;
        st_pausing  = 1'b0;
        st_pause    = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_symbol_rules();
        test_empty_pattern();
        test_longest_pause();
        test_output_backpressure();
        test_slowest_unit();
        test_random_settings(5);

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d ticks and checked %0d words.", ticks_sent, words_checked);
        $display("Covered %0d units, %0d tone loads and %0d pattern restarts.",
                 units_due, loads_due, restarts_due);
        if (mismatches == 0) begin
            $display("fsk_morse_beacon_keyer_top_tb: clean");
        end else begin
            $display("fsk_morse_beacon_keyer_top_tb: errors");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d words outstanding", $time, tone_words_due.size());
        $display("fsk_morse_beacon_keyer_top_tb: errors");
        $finish;
    end

endmodule
